// File: sv/utf8d_pkg.sv
package utf8d_pkg;

  // Field widths
  localparam int unsigned CodeW = 31;
  localparam int unsigned ByteW = 8;

  // Replacement code after reset
  localparam logic [CodeW-1:0] ReplReset = 31'h0000FFFD;

  // Least legal values for each sequence length
  localparam logic [CodeW-1:0] MinLen2 = 31'h00000080;
  localparam logic [CodeW-1:0] MinLen3 = 31'h00000800;
  localparam logic [CodeW-1:0] MinLen4 = 31'h00010000;
  localparam logic [CodeW-1:0] MinLen5 = 31'h00200000;
  localparam logic [CodeW-1:0] MinLen6 = 31'h04000000;

  // Surrogate range and noncharacters rejected in three-byte form
  localparam logic [CodeW-1:0] SurrLo  = 31'h0000D800;
  localparam logic [CodeW-1:0] SurrHi  = 31'h0000DFFF;
  localparam logic [CodeW-1:0] NonChA  = 31'h0000FFFE;
  localparam logic [CodeW-1:0] NonChB  = 31'h0000FFFF;

  // Sequence lengths
  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;
  localparam logic [2:0] Len4 = 3'd4;
  localparam logic [2:0] Len5 = 3'd5;
  localparam logic [2:0] Len6 = 3'd6;

  // Byte classes
  localparam logic [1:0] ContTag = 2'b10;

  // One result item
  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic             is_replacement;
    logic             end_of_text;
    logic             last;
  } result_t;

  // Decoder state carried between bytes
  typedef struct packed {
    logic [CodeW-1:0] partial_code;
    logic [2:0]       bytes_owed;
    logic [2:0]       sequence_length;
  } dec_state_t;

endpackage

// File: sv/utf8d_decode.sv
module utf8d_decode
  import utf8d_pkg::*;
(
  input  logic [ByteW-1:0] in_byte,
  input  dec_state_t       state,
  input  logic [CodeW-1:0] repl_code,
  output dec_state_t       state_next,
  output result_t          res0,
  output result_t          res1,
  output logic [1:0]       res_count
);

  // Checks a completed sequence against overlong, surrogate and noncharacter rules.
  function automatic logic code_ok(input logic [CodeW-1:0] cp, input logic [2:0] len);
    logic ok;
    begin
      ok = 1'b0;
      case (len)
        Len2: ok = (cp >= MinLen2);
        Len3: ok = (cp >= MinLen3) && !((cp >= SurrLo) && (cp <= SurrHi)) &&
                   (cp != NonChA) && (cp != NonChB);
        Len4: ok = (cp >= MinLen4);
        Len5: ok = (cp >= MinLen5);
        Len6: ok = (cp >= MinLen6);
        default: ok = 1'b0;
      endcase
      return ok;
    end
  endfunction

  result_t          lead_res;
  logic             lead_has_res;
  dec_state_t       lead_state;
  result_t          repl_res;
  logic [CodeW-1:0] cont_bits;
  logic [CodeW-1:0] cont_shifted;
  logic [CodeW-1:0] merged;
  logic [2:0]       owed_dec;
  logic             is_cont;

  // Lead byte handling, as if no sequence were open.
  always_comb begin
    lead_res     = '0;
    lead_has_res = 1'b0;
    lead_state   = '0;
    if (!in_byte[7]) begin
      lead_res.code_point = {{(CodeW-ByteW){1'b0}}, in_byte};
      lead_has_res        = 1'b1;
    end else if (in_byte[7:5] == 3'b110) begin
      lead_state.sequence_length = Len2;
      lead_state.bytes_owed      = Len2 - 3'd1;
      lead_state.partial_code    = {{(CodeW-5){1'b0}}, in_byte[4:0]} << 6;
    end else if (in_byte[7:4] == 4'b1110) begin
      lead_state.sequence_length = Len3;
      lead_state.bytes_owed      = Len3 - 3'd1;
      lead_state.partial_code    = {{(CodeW-4){1'b0}}, in_byte[3:0]} << 12;
    end else if (in_byte[7:3] == 5'b11110) begin
      lead_state.sequence_length = Len4;
      lead_state.bytes_owed      = Len4 - 3'd1;
      lead_state.partial_code    = {{(CodeW-3){1'b0}}, in_byte[2:0]} << 18;
    end else if (in_byte[7:2] == 6'b111110) begin
      lead_state.sequence_length = Len5;
      lead_state.bytes_owed      = Len5 - 3'd1;
      lead_state.partial_code    = {{(CodeW-2){1'b0}}, in_byte[1:0]} << 24;
    end else if (in_byte[7:1] == 7'b1111110) begin
      lead_state.sequence_length = Len6;
      lead_state.bytes_owed      = Len6 - 3'd1;
      lead_state.partial_code    = {{(CodeW-1){1'b0}}, in_byte[0]} << 30;
    end else begin
      lead_res.code_point     = repl_code;
      lead_res.is_replacement = 1'b1;
      lead_has_res            = 1'b1;
    end
  end

  // Continuation byte bits placed by the number of bytes still owed.
  always_comb begin
    cont_bits = {{(CodeW-6){1'b0}}, in_byte[5:0]};
    case (state.bytes_owed)
      3'd2:    cont_shifted = cont_bits << 6;
      3'd3:    cont_shifted = cont_bits << 12;
      3'd4:    cont_shifted = cont_bits << 18;
      3'd5:    cont_shifted = cont_bits << 24;
      default: cont_shifted = cont_bits;
    endcase
    merged   = state.partial_code | cont_shifted;
    owed_dec = state.bytes_owed - 3'd1;
    is_cont  = (in_byte[7:6] == ContTag);
  end

  // Result selection and next state.
  always_comb begin
    repl_res                = '0;
    repl_res.code_point     = repl_code;
    repl_res.is_replacement = 1'b1;
    state_next = state;
    res0       = '0;
    res1       = '0;
    res_count  = 2'd0;
    if (in_byte == '0) begin
      // End of text drops any open sequence.
      state_next       = '0;
      res0.end_of_text = 1'b1;
      res0.last        = 1'b1;
      res_count        = 2'd1;
    end else if ((state.bytes_owed != 3'd0) && is_cont) begin
      if (owed_dec != 3'd0) begin
        state_next.partial_code = merged;
        state_next.bytes_owed   = owed_dec;
      end else begin
        state_next = '0;
        if (code_ok(merged, state.sequence_length)) begin
          res0.code_point = merged;
        end else begin
          res0 = repl_res;
        end
        res0.last = 1'b1;
        res_count = 2'd1;
      end
    end else if (state.bytes_owed != 3'd0) begin
      // Interrupted sequence: replacement, then the byte again as a lead.
      state_next = lead_state;
      res0       = repl_res;
      if (lead_has_res) begin
        res1      = lead_res;
        res1.last = 1'b1;
        res_count = 2'd2;
      end else begin
        res0.last = 1'b1;
        res_count = 2'd1;
      end
    end else begin
      state_next = lead_state;
      res0       = lead_res;
      res0.last  = lead_has_res;
      res_count  = {1'b0, lead_has_res};
    end
  end

endmodule

// File: sv/utf8d_out_queue.sv
module utf8d_out_queue
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  result_t    push0,
  input  result_t    push1,
  input  logic       pop,
  output result_t    head,
  output logic       not_empty,
  output logic [1:0] count
);

  result_t    q0;
  result_t    q1;
  result_t    q0_next;
  result_t    q1_next;
  logic [1:0] count_next;
  logic [1:0] kept;

  // Pop shifts the second entry forward; pushes fill behind what is kept.
  always_comb begin
    q0_next = q0;
    q1_next = q1;
    kept    = count;
    if (pop) begin
      q0_next = q1;
      kept    = count - 2'd1;
    end
    if (push_count != 2'd0) begin
      if (kept == 2'd0) begin
        q0_next = push0;
        if (push_count == 2'd2) begin
          q1_next = push1;
        end
      end else begin
        q1_next = push0;
      end
    end
    count_next = kept + push_count;
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

  assign head      = q0;
  assign not_empty = (count != 2'd0);

endmodule

// File: sv/utf8_stream_decoder_unit.sv
// Channel   | Direction | Handshake          | Payload
// input     | in        | in_valid/in_stall  | in_byte
// output    | out       | out_valid/out_stall| code_point, is_replacement, end_of_text, last
// config    | in        | cfg_wr_en          | cfg_wr_data (replacement code)
//
// One byte is taken per cycle while the input is not stalled; a byte whose results
// do not fit in the two-entry result queue, after this cycle's pop, holds the input
// register until they do. An accepted byte goes from the input register into the queue.
// Synchronous reset clears the open sequence, the input register, the queue
// and sets the replacement code to U+FFFD; there is no clearing pass.
// A stall on the output fills the queue, then stalls the input.
module utf8_stream_decoder_unit
  import utf8d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] in_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CodeW-1:0] code_point,
  output logic             is_replacement,
  output logic             end_of_text,
  output logic             last,
  input  logic             cfg_wr_en,
  input  logic [CodeW-1:0] cfg_wr_data
);

  logic [CodeW-1:0] repl_code;
  logic             byte_valid;
  logic [ByteW-1:0] byte_reg;
  dec_state_t       state;
  dec_state_t       state_next;
  result_t          res0;
  result_t          res1;
  logic [1:0]       res_count;
  logic [1:0]       push_count;
  logic [1:0]       q_count;
  result_t          head;
  logic             advance;
  logic             take;
  logic             pop;

  // Replacement code register.
  always_ff @(posedge clk) begin
    if (rst) begin
      repl_code <= ReplReset;
    end else if (cfg_wr_en) begin
      repl_code <= cfg_wr_data;
    end
  end

  // The held byte moves on when the queue, after this cycle's pop, has room for all its results.
  assign pop      = out_valid && !out_stall;
  assign advance  = byte_valid &&
                    (({1'b0, q_count} + {1'b0, res_count}) <= (3'd2 + {2'b0, pop}));
  assign in_stall = byte_valid && !advance;
  assign take     = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (take) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_reg <= in_byte;
    end
  end

  // Sequence state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  utf8d_decode u_decode (
    .in_byte    (byte_reg),
    .state      (state),
    .repl_code  (repl_code),
    .state_next (state_next),
    .res0       (res0),
    .res1       (res1),
    .res_count  (res_count)
  );

  assign push_count = advance ? res_count : 2'd0;

  utf8d_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .pop        (pop),
    .head       (head),
    .not_empty  (out_valid),
    .count      (q_count)
  );

  assign code_point     = head.code_point;
  assign is_replacement = head.is_replacement;
  assign end_of_text    = head.end_of_text;
  assign last           = head.last;

endmodule

// File: sv/utf8d_check.sv
module utf8d_check
  import utf8d_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CodeW-1:0] code_point,
  input logic             is_replacement,
  input logic             end_of_text,
  input logic             last
);

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // An end-of-text result is zero, unflagged and final.
  a_eot_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_text |-> (code_point == '0) && !is_replacement && last)
    else $error("malformed end-of-text result");

  // Only an interrupted sequence gives a first, non-final result: a replacement.
  a_first_is_repl: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> is_replacement && !end_of_text)
    else $error("non-final result is not a replacement");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_point) && $stable(last))
    else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_unit utf8d_check u_check (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .code_point     (code_point),
  .is_replacement (is_replacement),
  .end_of_text    (end_of_text),
  .last           (last)
);
